// ----- sv/self_driving_symbol_automaton_assert.svh -----
// assertion macros for the self-driving symbol automaton
// used by the checker module; no other dependencies
`ifndef SELF_DRIVING_SYMBOL_AUTOMATON_ASSERT_SVH
`define SELF_DRIVING_SYMBOL_AUTOMATON_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SDSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SDSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sdsa_pkg.sv -----
// shared types and constants of the self-driving symbol automaton
// no dependencies; imported by every module of the block
package sdsa_pkg;

    localparam int FUNC_W      = 2;
    localparam int STATE_W     = 4;
    localparam int SYM_W       = 3;
    localparam int RLEN_W      = 2;
    localparam int RESP_W      = 7;
    localparam int RESP_TWO_BIT = 6;

    localparam int NUM_STATES  = 16;
    localparam int NUM_SYMBOLS = 6;

    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = FUNC_W;
    localparam int M_TDATA_W   = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_INIT_INPUT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_STATE = 1'b1;

    localparam logic [RLEN_W-1:0] RLEN_ONE = 2'd1;
    localparam logic [RLEN_W-1:0] RLEN_TWO = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_TRANS = 2'd0,
        FUNC_WR_RESP  = 2'd1,
        FUNC_RESTART  = 2'd2,
        FUNC_STEP     = 2'd3
    } func_t;

    typedef struct packed {
        logic wr_trans;
        logic wr_resp;
        logic restart;
        logic fetch;
        logic pop;
        logic tbl_rd;
        logic push_first;
        logic push_second;
        logic load_out;
    } sdsa_cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic sym_in_range;
        logic resp_two;
    } sdsa_status_t;

endpackage

// ----- sv/self_driving_symbol_automaton.sv -----
// top level of the self-driving symbol automaton
// depends on sdsa_pkg, sdsa_ctrl and sdsa_datapath
//
//  channel  | direction | transfer when          | contents
//  s_axis   | in        | tvalid & tready        | func in tuser, table writes in tdata
//  m_axis   | out       | tvalid & tready        | popped symbol and overflow flag
//  cfg      | in        | cfg_valid & cfg_ready  | init_input (0), init_state (1)
//
// writes and restart finish without leaving idle; a step on a nonempty queue fetches the
// head symbol, pops it and reads the tables, pushes the one or two response symbols in
// turn through the one queue write port, then emits; an out-of-range symbol skips to emit
// reset clears control state only; tables and queue hold garbage until written
// a result waits in the output register; a stalled result holds the step in its last cycle
module self_driving_symbol_automaton #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // state_index[3:0] symbol[6:4] next_state[10:7] resp_len[12:11]
    // resp_first[15:13] resp_second[18:16], zero above
    input  logic [sdsa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  logic [sdsa_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // symbol_out[2:0] overflow[3], zero above
    output logic [sdsa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sdsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sdsa_pkg::*;

    sdsa_cmd_t    cmd;
    sdsa_status_t status;
    logic [SYM_W-1:0] symbol_out;
    logic             overflow;

    assign cfg_ready = 1'b1;

    sdsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .func      (func_t'(s_axis_tuser)),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sdsa_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .state_index (s_axis_tdata[3:0]),
        .symbol      (s_axis_tdata[6:4]),
        .next_state  (s_axis_tdata[10:7]),
        .resp_len    (s_axis_tdata[12:11]),
        .resp_first  (s_axis_tdata[15:13]),
        .resp_second (s_axis_tdata[18:16]),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .symbol_out  (symbol_out),
        .overflow    (overflow)
    );

    assign m_axis_tdata = {{(M_TDATA_W - SYM_W - 1){1'b0}}, overflow, symbol_out};

endmodule

// ----- sv/sdsa_ctrl.sv -----
// controller of the symbol automaton: state machine and handshakes
// depends on sdsa_pkg; drives sdsa_datapath through command signals
module sdsa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sdsa_pkg::func_t       func,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sdsa_pkg::sdsa_status_t status,
    output sdsa_pkg::sdsa_cmd_t   cmd
);
    import sdsa_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE        = 5'b00001,
        ST_POP         = 5'b00010,
        ST_PUSH_FIRST  = 5'b00100,
        ST_PUSH_SECOND = 5'b01000,
        ST_EMIT        = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign slot_free = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_trans = accept & (func == FUNC_WR_TRANS);
                cmd.wr_resp  = accept & (func == FUNC_WR_RESP);
                cmd.restart  = accept & (func == FUNC_RESTART);
                cmd.fetch    = accept & (func == FUNC_STEP) & ~status.queue_empty;
                if (cmd.fetch)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                cmd.tbl_rd = status.sym_in_range;
                state_next = status.sym_in_range ? ST_PUSH_FIRST : ST_EMIT;
            end
            ST_PUSH_FIRST:
            begin
                cmd.push_first = 1'b1;
                state_next     = status.resp_two ? ST_PUSH_SECOND : ST_EMIT;
            end
            ST_PUSH_SECOND:
            begin
                cmd.push_second = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/sdsa_datapath.sv -----
// datapath of the symbol automaton: tables, symbol queue, state and result registers
// depends on sdsa_pkg; commanded by sdsa_ctrl
module sdsa_datapath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sdsa_pkg::sdsa_cmd_t             cmd,
    output sdsa_pkg::sdsa_status_t          status,
    input  logic [sdsa_pkg::STATE_W-1:0]    state_index,
    input  logic [sdsa_pkg::SYM_W-1:0]      symbol,
    input  logic [sdsa_pkg::STATE_W-1:0]    next_state,
    input  logic [sdsa_pkg::RLEN_W-1:0]     resp_len,
    input  logic [sdsa_pkg::SYM_W-1:0]      resp_first,
    input  logic [sdsa_pkg::SYM_W-1:0]      resp_second,
    input  logic                            cfg_we,
    input  logic [sdsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdsa_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [sdsa_pkg::SYM_W-1:0]      symbol_out,
    output logic                            overflow
);
    import sdsa_pkg::*;

    localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int QAW       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = QAW + 1;
    localparam int MOD_W     = 9;

    logic [STATE_W-1:0] trans_mem [TBL_DEPTH];
    logic [RESP_W-1:0]  resp_mem  [TBL_DEPTH];
    logic [SYM_W-1:0]   queue_mem [QUEUE_DEPTH];

    logic [STATE_W-1:0] trans_rd_reg;
    logic [RESP_W-1:0]  resp_rd_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [SYM_W-1:0]   out_sym_reg;
    logic               out_ovf_reg;

    logic [QAW-1:0]     head_reg,        head_next;
    logic [CNT_W-1:0]   count_reg,       count_next;
    logic [STATE_W-1:0] cur_state_reg,   cur_state_next;
    logic               ovf_reg,         ovf_next;
    logic [SYM_W-1:0]   init_input_reg,  init_input_next;
    logic [STATE_W-1:0] init_state_reg,  init_state_next;

    logic               row_ok;
    logic               col_ok;
    logic               first_ok;
    logic               second_ok;
    logic               trans_we;
    logic               resp_we;
    logic [RESP_W-1:0]  resp_word;
    logic [TBL_AW-1:0]  wr_idx;
    logic [TBL_AW-1:0]  rd_idx;

    logic               push;
    logic               full;
    logic [SUM_W-1:0]   tail_sum;
    logic [SUM_W-1:0]   tail_wrap;
    logic               q_we;
    logic [QAW-1:0]     q_waddr;
    logic [SYM_W-1:0]   q_wdata;
    logic [MOD_W-1:0]   init_mod;

    // table write checks and addressing
    assign row_ok    = int'(state_index) < NUM_STATES;
    assign col_ok    = int'(symbol) < NUM_SYMBOLS;
    assign first_ok  = int'(resp_first) < NUM_SYMBOLS;
    assign second_ok = int'(resp_second) < NUM_SYMBOLS;
    assign trans_we  = cmd.wr_trans & row_ok & col_ok & (int'(next_state) < NUM_STATES);
    assign resp_we   = cmd.wr_resp & row_ok & col_ok & first_ok &
                       ((resp_len == RLEN_ONE) | ((resp_len == RLEN_TWO) & second_ok));
    assign resp_word = (resp_len == RLEN_TWO) ? {1'b1, resp_second, resp_first}
                                              : {1'b0, {SYM_W{1'b0}}, resp_first};
    assign wr_idx    = TBL_AW'(state_index) * TBL_AW'(NUM_SYMBOLS) + TBL_AW'(symbol);
    assign rd_idx    = TBL_AW'(cur_state_reg) * TBL_AW'(NUM_SYMBOLS) + TBL_AW'(sym_reg);

    // queue tail position
    assign push      = cmd.push_first | cmd.push_second;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                         : tail_sum;

    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = tail_wrap[QAW-1:0];
        q_wdata = cmd.push_second ? resp_rd_reg[2*SYM_W-1:SYM_W] : resp_rd_reg[SYM_W-1:0];
        if (cmd.restart)
        begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = init_input_reg;
        end
        else if (push & ~full)
        begin
            q_we = 1'b1;
        end
    end

    // restart state reduced into the state range
    always_comb
    begin
        init_mod = MOD_W'(init_state_reg);
        for (int i = 0; i < 8; i++)
        begin
            if (init_mod >= MOD_W'(NUM_STATES))
            begin
                init_mod = init_mod - MOD_W'(NUM_STATES);
            end
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        cur_state_next = cur_state_reg;
        ovf_next       = ovf_reg;
        if (cmd.restart)
        begin
            head_next      = '0;
            count_next     = CNT_W'(1);
            cur_state_next = init_mod[STATE_W-1:0];
            ovf_next       = 1'b0;
        end
        else if (cmd.pop)
        begin
            head_next  = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QAW'(1);
            count_next = count_reg - CNT_W'(1);
        end
        else if (push)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.push_first)
        begin
            cur_state_next = trans_rd_reg;
        end
    end

    always_comb
    begin
        init_input_next = init_input_reg;
        init_state_next = init_state_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_INIT_INPUT: init_input_next = cfg_data[SYM_W-1:0];
                REG_INIT_STATE: init_state_next = cfg_data[STATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            cur_state_reg  <= '0;
            ovf_reg        <= 1'b0;
            init_input_reg <= '0;
            init_state_reg <= '0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            cur_state_reg  <= cur_state_next;
            ovf_reg        <= ovf_next;
            init_input_reg <= init_input_next;
            init_state_reg <= init_state_next;
        end
    end

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        if (trans_we)
        begin
            trans_mem[wr_idx] <= next_state;
        end
        if (resp_we)
        begin
            resp_mem[wr_idx] <= resp_word;
        end
        if (cmd.tbl_rd)
        begin
            trans_rd_reg <= trans_mem[rd_idx];
            resp_rd_reg  <= resp_mem[rd_idx];
        end
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (cmd.fetch)
        begin
            sym_reg <= queue_mem[head_reg];
        end
        if (cmd.load_out)
        begin
            out_sym_reg <= sym_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign status.queue_empty  = (count_reg == '0);
    assign status.sym_in_range = int'(sym_reg) < NUM_SYMBOLS;
    assign status.resp_two     = resp_rd_reg[RESP_TWO_BIT];

    assign symbol_out = out_sym_reg;
    assign overflow   = out_ovf_reg;

endmodule

// ----- sv/sdsa_checker.sv -----
// port checker for the self-driving symbol automaton, bound to the top level
// depends on sdsa_pkg and self_driving_symbol_automaton_assert.svh
`include "self_driving_symbol_automaton_assert.svh"

module sdsa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [sdsa_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sdsa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import sdsa_pkg::*;

    logic in_xfer;

    assign in_xfer = s_axis_tvalid & s_axis_tready;

    // stalled result holds its value
    `SDSA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid & ~m_axis_tready,
        m_axis_tvalid & $stable(m_axis_tdata), "result changed while stalled")

    // the input is ready again in the cycle after a write or restart
    `SDSA_ASSERT_NEXT(a_short_ops, clk, rst_n,
        in_xfer & (s_axis_tuser != FUNC_STEP), s_axis_tready,
        "input not ready after a write or restart")

    // a step never delivers its result in the next cycle
    `SDSA_ASSERT_NEXT(a_step_latency, clk, rst_n, in_xfer,
        !$rose(m_axis_tvalid), "result appeared too early after a step")

    // padding bits of the result stay zero
    `SDSA_ASSERT_IMPLY(a_out_pad, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[M_TDATA_W-1:SYM_W+1] == '0, "result padding not zero")

endmodule

bind self_driving_symbol_automaton sdsa_checker u_sdsa_checker (.*);
